>>> design/hsaqi_pkg.sv
// hsaqi_pkg: shared types, constants and segment tables for the hourly
// dust averaging and aqi block
// no dependencies
package hsaqi_pkg;

   localparam int NumSensors = 16;
   localparam int IdxBits    = 4;
   localparam int IdBits     = 5;
   localparam int CountBits  = 16;
   localparam int SumBits    = 30;
   localparam int KeyBits    = 32;
   localparam int SampleBits = 16;
   localparam int AvgBits    = 13;
   localparam int AqiBits    = 9;
   localparam int LevelBits  = 3;
   localparam int SegBits    = 3;
   localparam int NumSegs    = 7;
   localparam int DeltaBits  = 7;
   localparam int DivBits    = 35;
   localparam int StepBits   = 4;

   localparam logic [AvgBits-1:0]   MaxSample   = 13'd5505;
   localparam logic [IdBits-1:0]    ActiveReset = 5'd16;
   localparam logic [CountBits-1:0] CountLimit  = {CountBits{1'b1}};

   // request action codes
   localparam logic ActSample = 1'b0;
   localparam logic ActEnd    = 1'b1;

   typedef struct packed {
      logic                         action;
      logic [IdBits-1:0]            sensor_id;
      logic [KeyBits-1:0]           hour_key;
      logic signed [SampleBits-1:0] sample_value;
   } hsaqi_req_type;

   typedef struct packed {
      logic [IdBits-1:0]    sensor_id_res;
      logic [KeyBits-1:0]   hour_key_res;
      logic [AvgBits-1:0]   average;
      logic [AqiBits-1:0]   aqi;
      logic [LevelBits-1:0] level;
      logic                 last;
   } hsaqi_rsp_type;

   typedef struct packed {
      logic                start;
      logic [StepBits-1:0] steps;
   } hsaqi_div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [AvgBits-1:0] quotient;
   } hsaqi_div_stat_type;

   function automatic logic [AvgBits-1:0] seg_lo_f(input logic [SegBits-1:0] seg);
      logic [AvgBits-1:0] v;
      case (seg)
         3'd0:    v = 13'd0;
         3'd1:    v = 13'd120;
         3'd2:    v = 13'd355;
         3'd3:    v = 13'd555;
         3'd4:    v = 13'd1505;
         3'd5:    v = 13'd2505;
         default: v = 13'd3505;
      endcase
      return v;
   endfunction

   function automatic logic [AvgBits-1:0] seg_hi_f(input logic [SegBits-1:0] seg);
      logic [AvgBits-1:0] v;
      case (seg)
         3'd0:    v = 13'd120;
         3'd1:    v = 13'd355;
         3'd2:    v = 13'd555;
         3'd3:    v = 13'd1505;
         3'd4:    v = 13'd2505;
         3'd5:    v = 13'd3505;
         default: v = 13'd5505;
      endcase
      return v;
   endfunction

   // width of each concentration segment
   function automatic logic [AvgBits-1:0] seg_span_f(input logic [SegBits-1:0] seg);
      logic [AvgBits-1:0] v;
      case (seg)
         3'd0:    v = 13'd120;
         3'd1:    v = 13'd235;
         3'd2:    v = 13'd200;
         3'd3:    v = 13'd950;
         3'd4:    v = 13'd1000;
         3'd5:    v = 13'd1000;
         default: v = 13'd2000;
      endcase
      return v;
   endfunction

   function automatic logic [AqiBits-1:0] aqi_lo_f(input logic [SegBits-1:0] seg);
      logic [AqiBits-1:0] v;
      case (seg)
         3'd0:    v = 9'd0;
         3'd1:    v = 9'd50;
         3'd2:    v = 9'd100;
         3'd3:    v = 9'd150;
         3'd4:    v = 9'd200;
         3'd5:    v = 9'd300;
         default: v = 9'd400;
      endcase
      return v;
   endfunction

   function automatic logic [DeltaBits-1:0] aqi_span_f(input logic [SegBits-1:0] seg);
      logic [DeltaBits-1:0] v;
      case (seg)
         3'd0, 3'd1, 3'd2, 3'd3: v = 7'd50;
         default:                v = 7'd100;
      endcase
      return v;
   endfunction

   function automatic logic [LevelBits-1:0] level_f(input logic [AqiBits-1:0] aqi);
      logic [LevelBits-1:0] v;
      if (aqi <= 9'd50) begin
         v = 3'd0;
      end else if (aqi <= 9'd100) begin
         v = 3'd1;
      end else if (aqi <= 9'd150) begin
         v = 3'd2;
      end else if (aqi <= 9'd200) begin
         v = 3'd3;
      end else if (aqi <= 9'd300) begin
         v = 3'd4;
      end else if (aqi <= 9'd400) begin
         v = 3'd5;
      end else begin
         v = 3'd6;
      end
      return v;
   endfunction

endpackage

>>> design/hsaqi_req_if.sv
// hsaqi_req_if: valid/ready channel that carries one sample or end request
// depends on hsaqi_pkg
interface hsaqi_req_if
   import hsaqi_pkg::*;
();
   logic          valid;
   logic          ready;
   hsaqi_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/hsaqi_rsp_if.sv
// hsaqi_rsp_if: valid/ready channel that carries one hourly sensor result
// depends on hsaqi_pkg
interface hsaqi_rsp_if
   import hsaqi_pkg::*;
();
   logic          valid;
   logic          ready;
   hsaqi_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/hsaqi_divider.sv
// hsaqi_divider: restoring divider, one quotient bit per cycle
// depends on hsaqi_pkg; denominator comes in pre-aligned to the top quotient bit
module hsaqi_divider
   import hsaqi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  hsaqi_div_cmd_type  cmd,
   input  logic [DivBits-1:0] num,
   input  logic [DivBits-1:0] den,
   output hsaqi_div_stat_type stat
);

   logic                run_ff;
   logic                done_ff;
   logic [StepBits-1:0] cnt_ff;
   logic [DivBits-1:0]  rem_ff;
   logic [DivBits-1:0]  dsh_ff;
   logic [AvgBits-1:0]  quot_ff;

   logic                fits;
   logic [DivBits-1:0]  rem_in;
   logic [AvgBits-1:0]  quot_in;

   always_comb begin
      fits    = rem_ff >= dsh_ff;
      rem_in  = fits ? rem_ff - dsh_ff : rem_ff;
      quot_in = {quot_ff[AvgBits-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // done pulses for one cycle after the final step
         done_ff <= !cmd.start && run_ff && cnt_ff == StepBits'(1);
         if (cmd.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == StepBits'(1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff  <= num;
         dsh_ff  <= den;
         cnt_ff  <= cmd.steps;
         quot_ff <= '0;
      end else if (run_ff) begin
         rem_ff  <= rem_in;
         dsh_ff  <= dsh_ff >> 1;
         cnt_ff  <= cnt_ff - StepBits'(1);
         quot_ff <= quot_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quot_ff;

endmodule

>>> design/hourly_sensor_average_aqi_top.sv
// hourly_sensor_average_aqi_top: per-sensor hourly dust averaging with aqi
// depends on hsaqi_pkg, hsaqi_req_if, hsaqi_rsp_if, hsaqi_divider
//
// usage:
//   req_chan takes one request at a time: a dust sample (tenths of ug/m3,
//   sensor id, hour key) or an end-of-data marker. ready is high only while
//   the sequencer is idle.
//   a sample with a new hour key, or an end marker, closes the open hour:
//   sensors 1..16 are walked in id order and each sensor with data yields
//   one result on rsp_chan (mean, aqi, level, last on the final one).
//   csr_wr_en/csr_wr_data set the number of sensor ids in use; write only
//   while the block is idle.
// flow:
//   a sample that closes nothing is accepted in ST_IDLE and accumulated in
//   ST_APPLY. closing an hour steps past each empty sensor; a sensor with
//   data goes through the segment search over up to 7 segments, 3 multiply
//   steps, and 13 + 7 divider steps on the shared restoring divider plus
//   handoffs.
//   rsp_chan has one output register: a stalled receiver holds the walk at
//   the next result until the register frees up.
// reset:
//   synchronous, active high; clears all counts, the open hour and the
//   output register, and sets 16 sensors in use.
module hourly_sensor_average_aqi_top
   import hsaqi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [IdBits-1:0] csr_wr_data,
   hsaqi_req_if.sink         req_chan,
   hsaqi_rsp_if.source       rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEG,
      ST_LOMUL,
      ST_DENMUL,
      ST_NUMMUL,
      ST_DIVA,
      ST_DIVA_WAIT,
      ST_DIVQ,
      ST_DIVQ_WAIT,
      ST_EMIT,
      ST_APPLY
   } state_type;

   state_type state_ff;

   // configuration and hour bookkeeping
   logic [IdBits-1:0]  active_ff;
   logic [KeyBits-1:0] current_hour_ff;
   logic               hour_valid_ff;
   logic [KeyBits-1:0] close_key_ff;
   logic               apply_ff;

   // sample held until the close finishes
   logic [IdxBits-1:0] pend_idx_ff;
   logic [AvgBits-1:0] pend_raw_ff;

   // accumulators
   logic [SumBits-1:0]   sums_ff   [NumSensors];
   logic [CountBits-1:0] counts_ff [NumSensors];

   // per-sensor working registers
   logic [IdxBits-1:0]   idx_ff;
   logic [SumBits-1:0]   cur_sum_ff;
   logic [CountBits-1:0] cur_cnt_ff;
   logic [SegBits-1:0]   seg_ff;
   logic [SumBits-1:0]   lo_prod_ff;
   logic [SumBits-1:0]   diff_ff;
   logic [SumBits-1:0]   den_ff;
   logic [DivBits-1:0]   num_ff;
   logic [AvgBits-1:0]   avg_ff;
   logic [AqiBits-1:0]   aqi_ff;

   // output register
   logic          rsp_valid_ff;
   hsaqi_rsp_type rsp_data_ff;

   // divider hookup
   hsaqi_div_cmd_type  div_cmd;
   hsaqi_div_stat_type div_stat;
   logic [DivBits-1:0] div_num;
   logic [DivBits-1:0] div_den;

   // request decode
   logic [IdBits-1:0]     id_limit;
   logic [IdxBits-1:0]    req_idx;
   logic                  id_ok;
   logic                  value_ok;
   logic                  sample_ok;
   logic                  req_fire;

   logic [SumBits-1:0]    seg_prod;
   logic                  seg_hit;
   logic                  last_seg;
   logic                  out_free;
   logic                  walk_end;
   logic [NumSensors-1:0] has_data;
   logic                  more_above;
   logic                  cnt_full;

   // id range from the register, capped at the number of sensors
   always_comb begin
      id_limit  = (active_ff > IdBits'(NumSensors)) ? IdBits'(NumSensors) : active_ff;
      id_ok     = req_chan.data.sensor_id != '0 && req_chan.data.sensor_id <= id_limit;
      req_idx   = IdxBits'(req_chan.data.sensor_id - IdBits'(1));
      value_ok  = !req_chan.data.sample_value[SampleBits-1] &&
                  req_chan.data.sample_value[SampleBits-2:0] <= (SampleBits-1)'(MaxSample);
      sample_ok = id_ok && value_ok;
   end

   assign req_chan.ready = state_ff == ST_IDLE;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // segment search: first segment whose upper edge times count covers the sum
   always_comb begin
      seg_prod = SumBits'(seg_hi_f(seg_ff)) * SumBits'(cur_cnt_ff);
      last_seg = seg_ff == SegBits'(NumSegs - 1);
      seg_hit  = cur_sum_ff <= seg_prod || last_seg;
   end

   // last flag: nothing left to report above the current id
   always_comb begin
      more_above = 1'b0;
      for (int i = 0; i < NumSensors; i++) begin
         has_data[i] = counts_ff[i] != '0;
         if (has_data[i] && IdxBits'(i) > idx_ff) begin
            more_above = 1'b1;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign walk_end = idx_ff == IdxBits'(NumSensors - 1);
   assign cnt_full = counts_ff[pend_idx_ff] == CountLimit;

   // shared divider: mean first (13 quotient bits), then aqi offset (7 bits)
   always_comb begin
      div_cmd.start = state_ff == ST_DIVA || state_ff == ST_DIVQ;
      if (state_ff == ST_DIVA) begin
         div_cmd.steps = StepBits'(AvgBits);
         div_num       = DivBits'(cur_sum_ff);
         div_den       = DivBits'(cur_cnt_ff) << (AvgBits - 1);
      end else begin
         div_cmd.steps = StepBits'(DeltaBits);
         div_num       = num_ff;
         div_den       = DivBits'(den_ff) << (DeltaBits - 1);
      end
   end

   hsaqi_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat)
   );

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_ff       <= ActiveReset;
         current_hour_ff <= '0;
         hour_valid_ff   <= 1'b0;
         apply_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         // a new result takes the register as the old one leaves
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_chan.data.action == ActEnd) begin
                     hour_valid_ff <= 1'b0;
                     if (hour_valid_ff) begin
                        apply_ff <= 1'b0;
                        state_ff <= ST_LOAD;
                     end
                  end else if (sample_ok) begin
                     current_hour_ff <= req_chan.data.hour_key;
                     hour_valid_ff   <= 1'b1;
                     if (hour_valid_ff && req_chan.data.hour_key != current_hour_ff) begin
                        apply_ff <= 1'b1;
                        state_ff <= ST_LOAD;
                     end else begin
                        state_ff <= ST_APPLY;
                     end
                  end
               end
            end
            ST_LOAD: begin
               if (has_data[idx_ff]) begin
                  state_ff <= ST_SEG;
               end else if (walk_end) begin
                  state_ff <= apply_ff ? ST_APPLY : ST_IDLE;
               end
            end
            ST_SEG: begin
               if (seg_hit) begin
                  state_ff <= ST_LOMUL;
               end
            end
            ST_LOMUL:  state_ff <= ST_DENMUL;
            ST_DENMUL: state_ff <= ST_NUMMUL;
            ST_NUMMUL: state_ff <= ST_DIVA;
            ST_DIVA:   state_ff <= ST_DIVA_WAIT;
            ST_DIVA_WAIT: begin
               if (div_stat.done) begin
                  state_ff <= ST_DIVQ;
               end
            end
            ST_DIVQ: state_ff <= ST_DIVQ_WAIT;
            ST_DIVQ_WAIT: begin
               if (div_stat.done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  if (walk_end) begin
                     state_ff <= apply_ff ? ST_APPLY : ST_IDLE;
                  end else begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_APPLY: state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // working datapath, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            idx_ff       <= '0;
            close_key_ff <= current_hour_ff;
            pend_idx_ff  <= req_idx;
            pend_raw_ff  <= AvgBits'(req_chan.data.sample_value);
         end
         ST_LOAD: begin
            cur_sum_ff <= sums_ff[idx_ff];
            cur_cnt_ff <= counts_ff[idx_ff];
            seg_ff     <= '0;
            if (!has_data[idx_ff] && !walk_end) begin
               idx_ff <= idx_ff + IdxBits'(1);
            end
         end
         ST_SEG: begin
            if (!seg_hit) begin
               seg_ff <= seg_ff + SegBits'(1);
            end
         end
         ST_LOMUL: begin
            lo_prod_ff <= SumBits'(seg_lo_f(seg_ff)) * SumBits'(cur_cnt_ff);
         end
         ST_DENMUL: begin
            // sum below the lower edge gives no offset
            diff_ff <= (cur_sum_ff >= lo_prod_ff) ? cur_sum_ff - lo_prod_ff : '0;
            den_ff  <= SumBits'(seg_span_f(seg_ff)) * SumBits'(cur_cnt_ff);
         end
         ST_NUMMUL: begin
            num_ff <= DivBits'(aqi_span_f(seg_ff)) * DivBits'(diff_ff);
         end
         ST_DIVA_WAIT: begin
            if (div_stat.done) begin
               avg_ff <= div_stat.quotient;
            end
         end
         ST_DIVQ_WAIT: begin
            if (div_stat.done) begin
               aqi_ff <= aqi_lo_f(seg_ff) + AqiBits'(div_stat.quotient[DeltaBits-1:0]);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_data_ff.sensor_id_res <= IdBits'(idx_ff) + IdBits'(1);
               rsp_data_ff.hour_key_res  <= close_key_ff;
               rsp_data_ff.average       <= avg_ff;
               rsp_data_ff.aqi           <= aqi_ff;
               rsp_data_ff.level         <= level_f(aqi_ff);
               rsp_data_ff.last          <= !more_above;
               if (!walk_end) begin
                  idx_ff <= idx_ff + IdxBits'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // counts: cleared per sensor as its result goes out
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSensors; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (state_ff == ST_EMIT && out_free) begin
         counts_ff[idx_ff] <= '0;
      end else if (state_ff == ST_APPLY && !cnt_full) begin
         counts_ff[pend_idx_ff] <= counts_ff[pend_idx_ff] + CountBits'(1);
      end
   end

   // sums: an empty sensor restarts from the new sample
   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY && !cnt_full) begin
         if (counts_ff[pend_idx_ff] == '0) begin
            sums_ff[pend_idx_ff] <= SumBits'(pend_raw_ff);
         end else begin
            sums_ff[pend_idx_ff] <= sums_ff[pend_idx_ff] + SumBits'(pend_raw_ff);
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

>>> tb/hourly_aqi_checker.sv
`timescale 1ns / 1ps
// hourly_aqi_checker: watches the request and result channels of the hourly
// dust averaging block, predicts each sensor report and compares field by field
// depends on hsaqi_pkg, hsaqi_req_if, hsaqi_rsp_if
module hourly_aqi_checker
   import hsaqi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [IdBits-1:0] csr_wr_data,
   hsaqi_req_if              req_mon,
   hsaqi_rsp_if              rsp_mon,
   output int                failures,
   output int                outstanding,
   output int                requests_seen,
   output int                reports_seen
);

   // segment edges: concentration in tenths and the matching index values
   localparam longint unsigned ConcEdge [8] = '{0, 120, 355, 555, 1505, 2505, 3505, 5505};
   localparam longint unsigned IndexEdge [8] = '{0, 50, 100, 150, 200, 300, 400, 500};

   logic [SumBits-1:0]   dust_sum   [NumSensors];
   logic [CountBits-1:0] dust_count [NumSensors];
   logic [KeyBits-1:0]   open_hour;
   logic                 hour_open;
   logic [IdBits-1:0]    sensors_in_use;
   hsaqi_rsp_type        due_reports [$];
   int                   mismatches = 0;
   int                   n_req = 0;
   int                   n_rsp = 0;

   function automatic hsaqi_rsp_type hour_report(int idx);
      longint unsigned s, c, aqi, num, den;
      int              seg, lvl;
      hsaqi_rsp_type   r;
      s   = dust_sum[idx];
      c   = dust_count[idx];
      // first segment whose upper edge holds the exact mean
      seg = 6;
      for (int k = 6; k >= 0; k--) begin
         if (s <= ConcEdge[k+1] * c) begin
            seg = k;
         end
      end
      aqi = IndexEdge[seg];
      if (s >= ConcEdge[seg] * c) begin
         num = (IndexEdge[seg+1] - IndexEdge[seg]) * (s - ConcEdge[seg] * c);
         den = (ConcEdge[seg+1] - ConcEdge[seg]) * c;
         aqi = aqi + num / den;
      end
      lvl = 6;
      for (int k = 5; k >= 0; k--) begin
         if (aqi <= IndexEdge[k+1]) begin
            lvl = k;
         end
      end
      r.sensor_id_res = IdBits'(idx + 1);
      r.hour_key_res  = open_hour;
      r.average       = AvgBits'(s / c);
      r.aqi           = AqiBits'(aqi);
      r.level         = LevelBits'(lvl);
      r.last          = 1'b0;
      return r;
   endfunction

   task automatic close_hour_reports();
      hsaqi_rsp_type held;
      logic          have;
      have = 1'b0;
      for (int i = 0; i < NumSensors; i++) begin
         if (dust_count[i] != '0) begin
            if (have) begin
               due_reports.insert(due_reports.size(), held);
            end
            held = hour_report(i);
            have = 1'b1;
         end
      end
      if (have) begin
         held.last = 1'b1;
         due_reports.insert(due_reports.size(), held);
      end
      for (int i = 0; i < NumSensors; i++) begin
         dust_sum[i]   = '0;
         dust_count[i] = '0;
      end
   endtask

   task automatic absorb_request(hsaqi_req_type q);
      int lim, sid, v;
      if (q.action == ActEnd) begin
         if (hour_open) begin
            close_hour_reports();
         end
         hour_open = 1'b0;
      end else begin
         lim = (sensors_in_use > NumSensors) ? NumSensors : int'(sensors_in_use);
         sid = q.sensor_id;
         v   = int'($signed(q.sample_value));
         if (sid != 0 && sid <= lim && v >= 0 && v <= int'(MaxSample)) begin
            if (hour_open && q.hour_key != open_hour) begin
               close_hour_reports();
            end
            open_hour = q.hour_key;
            hour_open = 1'b1;
            // saturated sensors drop further samples of this hour
            if (dust_count[sid-1] != CountLimit) begin
               dust_sum[sid-1]   = dust_sum[sid-1] + SumBits'(v);
               dust_count[sid-1] = dust_count[sid-1] + CountBits'(1);
            end
         end
      end
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_report(hsaqi_rsp_type got);
      hsaqi_rsp_type want;
      if (due_reports.size() == 0) begin
         $error("unexpected report: sensor %0d hour %0d", got.sensor_id_res, got.hour_key_res);
         mismatches++;
      end else begin
         want = due_reports.pop_front();
         check_field("sensor_id_res", want.sensor_id_res, got.sensor_id_res);
         check_field("hour_key_res", want.hour_key_res, got.hour_key_res);
         check_field("average", want.average, got.average);
         check_field("aqi", want.aqi, got.aqi);
         check_field("level", want.level, got.level);
         check_field("last", want.last, got.last);
      end
   endtask

   // reports first: anything accepted now belongs to an earlier request
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSensors; i++) begin
            dust_sum[i]   = '0;
            dust_count[i] = '0;
         end
         open_hour      = '0;
         hour_open      = 1'b0;
         sensors_in_use = ActiveReset;
         due_reports.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_report(rsp_mon.data);
            n_rsp++;
         end
         if (csr_wr_en) begin
            sensors_in_use = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_request(req_mon.data);
            n_req++;
         end
      end
      failures      <= mismatches;
      outstanding   <= due_reports.size();
      requests_seen <= n_req;
      reports_seen  <= n_rsp;
   end

endmodule

>>> tb/hourly_sensor_average_aqi_top_tb.sv
`timescale 1ns / 1ps
// hourly_sensor_average_aqi_top_tb: clock, reset, request and register stimulus,
// random result back-pressure and the verdict; checking sits in hourly_aqi_checker
// depends on hsaqi_pkg, hsaqi_req_if, hsaqi_rsp_if, the block and the checker
module hourly_sensor_average_aqi_top_tb
   import hsaqi_pkg::*;
();

   localparam int RandomItems  = 250;
   localparam int NoIdleItems  = 60;     // back-to-back stretch, an hour per ten
   localparam int SettleCycles = 40;     // empty-sensor walk plus a sample update
   localparam int HoldCycles   = 600;    // long result stall, fills the block
   localparam int StallLimit   = 4000;   // cycles with no handshake at all

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [IdBits-1:0] csr_wr_data;
   int                failures, outstanding, requests_seen, reports_seen;

   // stimulus-side knobs shared with the result receiver
   logic allow_idle       = 1'b1;
   logic squeeze_go       = 1'b0;
   int   ids_in_use       = NumSensors;  // register value as the block clamps it
   int   settings_written = 0;

   hsaqi_req_if req_bus ();
   hsaqi_rsp_if rsp_bus ();

   always #10 clock = ~clock;

   hourly_sensor_average_aqi_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   hourly_aqi_checker aqi_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .failures      (failures),
      .outstanding   (outstanding),
      .requests_seen (requests_seen),
      .reports_seen  (reports_seen)
   );

   // one request per call; valid stays high into the next call unless a gap
   // is drawn, so back-to-back requests never lower and raise valid in one step
   task automatic send_request(input logic act, input int sid, input logic [31:0] key,
                               input int value);
      hsaqi_req_type item;
      int            gap;
      item.action       = act;
      item.sensor_id    = IdBits'(sid);
      item.hour_key     = key;
      item.sample_value = SampleBits'(value);
      gap = 0;
      if (allow_idle && $urandom_range(99) < 20) begin
         gap = $urandom_range(1, 5);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.data  <= item;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_dust(input int sid, input logic [31:0] key, input int value);
      send_request(ActSample, sid, key, value);
   endtask

   // end-of-data request; the unused fields carry random bits
   task automatic send_end();
      send_request(ActEnd, $urandom_range(0, 31), $urandom(), $urandom_range(0, 65535));
   endtask

   // stop offering, let every predicted report drain, then let the block settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_sensors(input int value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= IdBits'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ids_in_use = (value > NumSensors) ? NumSensors : value;
      settings_written++;
   endtask

   // in-range concentration, weighted toward segment edges and tiny values
   function automatic int good_dust();
      int border;
      case ($urandom_range(9))
         0, 1: begin
            border = seg_hi_f(SegBits'($urandom_range(0, 6))) - 1 + $urandom_range(0, 2);
            return (border > int'(MaxSample)) ? int'(MaxSample) : border;
         end
         2:       return $urandom_range(0, 20);
         default: return $urandom_range(0, int'(MaxSample));
      endcase
   endfunction

   // negative or above the sensor range, dropped by the block
   function automatic int outlier_value();
      if ($urandom_range(1) == 1) begin
         return -1 - int'($urandom_range(0, 32767));
      end
      return $urandom_range(int'(MaxSample) + 1, 32767);
   endfunction

   // id zero or above the ids in use
   function automatic int stray_id();
      if ($urandom_range(3) == 0) begin
         return 0;
      end
      return $urandom_range(ids_in_use + 1, 31);
   endfunction

   // result receiver: random stalls, none while idling is off, and one long
   // hold-off once the random part begins so the block backs up into its input
   initial begin : receiver
      logic held_off;
      held_off = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_go && !held_off) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_bus.ready <= !allow_idle || ($urandom_range(99) >= 20);
         end
      end
   end

   // watchdog: ends the run when no request and no result moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int          counted;
      int          burst;
      logic [31:0] key;

      // every input known from time zero
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end of data with no open hour: nothing comes back
      send_end();
      // an outlier before any hour must not open one
      send_dust(1, 32'h0000_1234, -5);
      // one sensor per segment edge, edges fall into the lower segment
      send_dust(1, 32'h0, 0);
      send_dust(2, 32'h0, 120);
      send_dust(3, 32'h0, 121);
      send_dust(4, 32'h0, 355);
      send_dust(5, 32'h0, 555);
      send_dust(6, 32'h0, 1505);
      send_dust(7, 32'h0, 2505);
      send_dust(8, 32'h0, 3505);
      send_dust(9, 32'h0, 5505);
      // mean of 120.5: average floors to 120 but the aqi leaves the first segment
      send_dust(10, 32'h0, 119);
      send_dust(10, 32'h0, 122);
      send_dust(16, 32'h0, 1);
      // outliers at both ends of the 16-bit range, sensor 11 stays empty
      send_dust(11, 32'h0, -1);
      send_dust(11, 32'h0, 5506);
      send_dust(11, 32'h0, -32768);
      send_dust(11, 32'h0, 32767);
      // ids outside the range in use are ignored
      send_dust(0, 32'h0, 50);
      send_dust(17, 32'h0, 50);
      send_dust(31, 32'h0, 50);
      // a new hour key closes hour zero, end of data closes the top key
      send_dust(12, 32'hFFFF_FFFF, 77);
      send_end();
      send_end();

      // register at zero: no id is accepted, so the end request finds no hour
      write_sensors(0);
      send_dust(1, 32'h3, 100);
      send_end();
      // register above the sensor count is clamped to all sixteen
      write_sensors(31);
      send_dust(16, 32'h3, 4000);
      send_dust(1, 32'h3, 0);
      send_end();
      // lowered register: sensors already holding data still report
      write_sensors(NumSensors);
      send_dust(9, 32'h7, 300);
      send_dust(14, 32'h7, 2000);
      write_sensors(3);
      send_end();
      send_dust(5, 32'h8, 10);
      send_dust(3, 32'h8, 10);
      send_end();
      // single sensor in use
      write_sensors(1);
      send_dust(1, 32'h9, 50);
      send_dust(2, 32'h9, 50);
      send_end();

      // back-to-back stretch: no idling on either side, an hour closes every
      // ten samples
      write_sensors(NumSensors);
      allow_idle = 1'b0;
      for (int i = 0; i < NoIdleItems; i++) begin
         send_dust($urandom_range(1, NumSensors), 32'h5EED_0000 + 32'(i / 10), good_dust());
      end
      send_end();
      wait_idle();
      allow_idle = 1'b1;

      // random hours: bursts of mostly good samples under one key, some noise,
      // repeated keys, neighbor keys, random keys and register changes
      squeeze_go = 1'b1;
      counted    = 0;
      key        = $urandom();
      while (counted < RandomItems) begin
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0:       write_sensors(1);
               1:       write_sensors(NumSensors);
               default: write_sensors($urandom_range(1, NumSensors));
            endcase
         end
         if ($urandom_range(9) >= 2) begin
            key = ($urandom_range(2) == 0) ? $urandom() : key + 1;
         end
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            if ($urandom_range(99) < 10) begin
               // noise the block drops or ignores
               if ($urandom_range(1) == 1) begin
                  send_dust($urandom_range(1, ids_in_use), key, outlier_value());
               end else begin
                  send_dust(stray_id(), key, good_dust());
               end
            end else begin
               send_dust($urandom_range(1, ids_in_use), key, good_dust());
            end
            counted++;
         end
         if ($urandom_range(3) == 0) begin
            send_end();
            counted++;
         end
      end
      wait_idle();

      $display("covered %0d requests and %0d sensor reports across %0d register writes",
               requests_seen, reports_seen, settings_written);
      $display("incl. segment edges, outliers, stray ids, a no-gap stretch, a long stall");
      if (failures == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
